FILE: design/hed_pkg.sv
// Shared types and constant tables for the HTML entity decoder.
package hed_pkg;

  localparam int ENT_COUNT  = 7;
  localparam int BODY_LEN   = 6;
  localparam int HOLD_DEPTH = 5;
  localparam int MAX_BURST  = 6;

  localparam logic [7:0] AMP = 8'h26;

  // Entity bodies after the ampersand: quot, lt, gt, #39, #039, amp, apos.
  localparam logic [7:0] ENT_BODY [ENT_COUNT][BODY_LEN] = '{
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00},
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h33, 8'h39, 8'h3B, 8'h00, 8'h00},
    '{8'h23, 8'h30, 8'h33, 8'h39, 8'h3B, 8'h00},
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00},
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00}
  };

  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{
    3'd5, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5
  };

  localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{
    8'h22, 8'h3C, 8'h3E, 8'h27, 8'h27, 8'h26, 8'h27
  };

  // All result bytes caused by one request, in output order.
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      text_end;
  } burst_t;

endpackage

FILE: design/hed_front.sv
// Front end: accepts input bytes, tracks entity candidates and builds result bursts.
module hed_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_stream_end,
  output logic            push,
  output hed_pkg::burst_t burst
);

  logic                                in_entity_r, in_entity_nxt;
  logic [2:0]                          held_cnt_r, held_cnt_nxt;
  logic [7:0]                          held_r [hed_pkg::HOLD_DEPTH];
  logic [hed_pkg::ENT_COUNT-1:0]       live_r, live_nxt;

  logic [hed_pkg::ENT_COUNT-1:0]       next_codes;
  logic                                done_found;
  logic [2:0]                          done_idx;
  logic                                is_amp;
  logic                                do_hold;

  // Candidate match against every live entity at the current position.
  always_comb begin
    next_codes = '0;
    done_found = 1'b0;
    done_idx   = '0;
    for (int i = 0; i < hed_pkg::ENT_COUNT; i++) begin
      if (live_r[i] && held_cnt_r < hed_pkg::ENT_LEN[i] &&
          hed_pkg::ENT_BODY[i][held_cnt_r] == in_byte) begin
        next_codes[i] = 1'b1;
        if (held_cnt_r + 3'd1 == hed_pkg::ENT_LEN[i] && !done_found) begin
          done_found = 1'b1;
          done_idx   = 3'(i);
        end
      end
    end
  end

  assign is_amp  = (in_byte == hed_pkg::AMP);
  assign do_hold = in_entity_r && !done_found && (next_codes != '0) &&
                   (held_cnt_r < 3'(hed_pkg::HOLD_DEPTH));

  // Burst contents and next matcher state.
  always_comb begin
    burst.bytes    = '0;
    burst.count    = '0;
    burst.text_end = in_stream_end;
    in_entity_nxt  = in_entity_r;
    held_cnt_nxt   = held_cnt_r;
    live_nxt       = live_r;
    priority if (!in_entity_r) begin
      burst.bytes[0] = in_byte;
      if (!is_amp) begin
        burst.count = 3'd1;
      end else if (in_stream_end) begin
        burst.count = 3'd1;
      end else begin
        in_entity_nxt = 1'b1;
        held_cnt_nxt  = '0;
        live_nxt      = '1;
      end
    end else if (done_found) begin
      burst.bytes[0] = hed_pkg::ENT_CHAR[done_idx];
      burst.count    = 3'd1;
      in_entity_nxt  = 1'b0;
      held_cnt_nxt   = '0;
      live_nxt       = '0;
    end else begin
      // A flush is the ampersand, the held bytes, then possibly this byte.
      burst.bytes[0] = hed_pkg::AMP;
      for (int k = 1; k < hed_pkg::MAX_BURST; k++) begin
        if (k - 1 < int'(held_cnt_r)) begin
          burst.bytes[k] = held_r[3'(k - 1)];
        end else begin
          burst.bytes[k] = in_byte;
        end
      end
      if (do_hold) begin
        if (in_stream_end) begin
          burst.count   = held_cnt_r + 3'd2;
          in_entity_nxt = 1'b0;
          held_cnt_nxt  = '0;
          live_nxt      = '0;
        end else begin
          held_cnt_nxt = held_cnt_r + 3'd1;
          live_nxt     = next_codes;
        end
      end else begin
        burst.count = held_cnt_r + 3'd1 + 3'((!is_amp || in_stream_end) ? 1 : 0);
        if (is_amp && !in_stream_end) begin
          in_entity_nxt = 1'b1;
          held_cnt_nxt  = '0;
          live_nxt      = '1;
        end else begin
          in_entity_nxt = 1'b0;
          held_cnt_nxt  = '0;
          live_nxt      = '0;
        end
      end
    end
  end

  assign push = accept && (burst.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entity_r <= 1'b0;
      held_cnt_r  <= '0;
      live_r      <= '0;
    end else if (accept) begin
      in_entity_r <= in_entity_nxt;
      held_cnt_r  <= held_cnt_nxt;
      live_r      <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_hold) begin
      held_r[held_cnt_r] <= in_byte;
    end
  end

  // The longest entity body completes on its fifth byte, so at most four are held.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r < 3'(hed_pkg::HOLD_DEPTH))
    else $error("held byte count out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_entity_r |-> (held_cnt_r == '0 && live_r == '0))
    else $error("matcher state not cleared outside an entity");

endmodule

FILE: design/hed_queue.sv
// Short queue of result bursts between the front end and the output stage.
module hed_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hed_pkg::burst_t push_data,
  input  logic            pop,
  output hed_pkg::burst_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hed_pkg::burst_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("burst pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("burst popped from an empty queue");

endmodule

FILE: design/hed_back.sv
// Output stage: serializes queued bursts into one result byte per cycle while out_stall is low.
module hed_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hed_pkg::burst_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_text_last
);

  logic [hed_pkg::MAX_BURST-1:0][7:0] cur_bytes_r, cur_bytes_nxt;
  logic [2:0]                         cur_rem_r, cur_rem_nxt;
  logic                               cur_end_r, cur_end_nxt;
  logic                               take;

  assign out_valid     = (cur_rem_r != '0);
  assign take          = out_valid && !out_stall;
  assign pop           = !empty && (!out_valid || (take && cur_rem_r == 3'd1));
  assign out_byte      = cur_bytes_r[0];
  assign out_run_last  = (cur_rem_r == 3'd1);
  assign out_text_last = (cur_rem_r == 3'd1) && cur_end_r;

  always_comb begin
    cur_bytes_nxt = cur_bytes_r;
    cur_rem_nxt   = cur_rem_r;
    cur_end_nxt   = cur_end_r;
    priority if (pop) begin
      cur_bytes_nxt = head.bytes;
      cur_rem_nxt   = head.count;
      cur_end_nxt   = head.text_end;
    end else if (take) begin
      for (int k = 0; k < hed_pkg::MAX_BURST - 1; k++) begin
        cur_bytes_nxt[k] = cur_bytes_r[k + 1];
      end
      cur_rem_nxt = cur_rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_rem_r <= '0;
    end else begin
      cur_rem_r <= cur_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_bytes_r <= cur_bytes_nxt;
    cur_end_r   <= cur_end_nxt;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_rem_r <= 3'(hed_pkg::MAX_BURST))
    else $error("remaining burst length out of range");

  a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !out_valid) |=> !out_valid)
    else $error("result appeared with nothing queued");

endmodule

FILE: design/html_entity_decoder_top.sv
// Top level of the streaming HTML entity decoder.
// The input channel takes one text byte per request on in_byte, with in_stream_end
// marking the final byte of a text. Seven entities (quot, lt, gt, #39, #039, apos,
// amp) are replaced by their byte; everything else passes through unchanged.
// Each result carries out_byte, out_run_last on the last byte caused by an input
// request, and out_text_last on the final byte of the text.
// A byte is accepted at a clock edge where in_valid is high and in_stall is low.
// Bytes that may still begin an entity are held and give no result until the
// match completes, breaks, or the text ends.
// The first result of a request is registered in the queue and then in the output
// stage before it is offered to the receiver.
// The input takes one byte per cycle while no request yields more than one result
// and out_stall stays low; a multi-byte flush holds the output stage until each
// byte is taken; the input stalls only once QUEUE_DEPTH bursts wait behind it.
// When the receiver raises out_stall the current result holds and the queue
// fills; in_stall rises when it is full.
// Synchronous reset clears the matcher, the queue and the output stage; no result
// is offered after reset until a new request arrives.
module html_entity_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_last
);

  hed_pkg::burst_t burst;
  hed_pkg::burst_t head;
  logic            accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  hed_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .push          (push),
    .burst         (burst)
  );

  hed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  hed_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_last (out_text_last)
  );

endmodule

FILE: tb/html_entity_decoder_top_tb.sv
// Self-checking testbench for the streaming HTML entity decoder.
module html_entity_decoder_top_tb;

  localparam logic [7:0] AMP_CHAR   = 8'h26;
  localparam int         HOLD_MAX   = 5;
  localparam int         RAND_ITEMS = 380;
  localparam int         HOLD_AT    = 150;
  localparam int         HOLD_LEN   = 250;
  localparam int         IDLE_LIMIT = 2000;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } encoded_item_t;

  typedef struct {
    logic [7:0] b;
    logic       run_last;
    logic       text_last;
  } decoded_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_stream_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_last;

  html_entity_decoder_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_stream_end(in_stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_last(out_text_last)
  );

  string      ent_name [7] = '{"quot;", "lt;", "gt;", "#39;", "#039;", "amp;", "apos;"};
  logic [7:0] ent_char [7] = '{8'h22, 8'h3C, 8'h3E, 8'h27, 8'h27, 8'h26, 8'h27};

  encoded_item_t encoded_q [$];
  decoded_char_t decoded_q [$];
  encoded_item_t next_item;

  // Decoder state as the predictor sees it.
  logic       matching = 1'b0;
  logic [2:0] held_n = 3'd0;
  logic [7:0] held [HOLD_MAX];
  logic [6:0] live = 7'd0;
  logic [7:0] run_bytes [$];

  int errors = 0;
  int bytes_sent = 0;
  int texts_seen = 0;
  int chars_seen = 0;
  int entities_decoded = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic void release_held();
    run_bytes.push_back(AMP_CHAR);
    for (int i = 0; i < held_n; i++) run_bytes.push_back(held[i]);
    matching = 1'b0;
    held_n = 3'd0;
    live = 7'd0;
  endfunction

  function automatic void begin_or_pass(logic [7:0] b);
    if (b == AMP_CHAR) begin
      matching = 1'b1;
      held_n = 3'd0;
      live = '1;
    end else begin
      run_bytes.push_back(b);
    end
  endfunction

  // Works out every decoded byte that one request gives and queues it.
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [6:0] next_live;
    int         hit;
    decoded_char_t c;
    next_live = '0;
    hit = -1;
    run_bytes.delete();
    if (!matching) begin
      begin_or_pass(b);
    end else begin
      for (int i = 0; i < 7; i++) begin
        if (live[i] && held_n < ent_name[i].len() && ent_name[i][held_n] == b) begin
          next_live[i] = 1'b1;
          if (held_n + 1 == ent_name[i].len() && hit < 0) hit = i;
        end
      end
      if (hit >= 0) begin
        run_bytes.push_back(ent_char[hit]);
        matching = 1'b0;
        held_n = 3'd0;
        live = 7'd0;
        entities_decoded++;
      end else if (next_live != 0 && held_n < HOLD_MAX) begin
        held[held_n] = b;
        held_n++;
        live = next_live;
      end else begin
        release_held();
        begin_or_pass(b);
      end
    end
    if (last) begin
      texts_seen++;
      if (matching) release_held();
    end
    for (int i = 0; i < run_bytes.size(); i++) begin
      c.b = run_bytes[i];
      c.run_last = (i == run_bytes.size() - 1);
      c.text_last = last && (i == run_bytes.size() - 1);
      decoded_q.push_back(c);
    end
  endfunction

  // Every third stretch of forty requests or results runs without any waiting.
  function automatic int draw_wait(int n);
    if ((n / 40) % 3 == 1) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    encoded_item_t it;
    it.b = b;
    it.last = last;
    encoded_q.push_back(it);
  endtask

  task automatic push_str(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], end_last && i == s.len() - 1);
  endtask

  task automatic push_prefix(input int e);
    int cut;
    cut = $urandom_range(0, ent_name[e].len() - 1);
    push_byte(AMP_CHAR, 1'b0);
    for (int i = 0; i < cut; i++) push_byte(ent_name[e][i], 1'b0);
  endtask

  // Well-formed entities in random text, with broken prefixes and noise.
  task automatic push_random_text();
    int            tokens;
    int            kind;
    int            e;
    encoded_item_t it;
    tokens = $urandom_range(1, 12);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 99);
      e = $urandom_range(0, 6);
      if (kind < 40) begin
        push_str({"&", ent_name[e]}, 1'b0);
      end else if (kind < 60) begin
        push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end else if (kind < 75) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 94) begin
        push_prefix(e);
        if ($urandom_range(0, 2) == 0) push_byte(AMP_CHAR, 1'b0);
        else push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_str("&&", 1'b0);
      end
    end
    if ($urandom_range(0, 3) == 0) push_prefix($urandom_range(0, 6));
    it = encoded_q.pop_back();
    it.last = 1'b1;
    encoded_q.push_back(it);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, in_stream_end);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (encoded_q.size() > 0) begin
          next_item = encoded_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_item.b;
          in_stream_end <= next_item.last;
          gap_left = draw_wait(bytes_sent);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    decoded_char_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got byte %h", $time,
                   out_byte);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.b) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.b, out_byte);
            errors++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: out_run_last expected %b, got %b", $time, want.run_last,
                     out_run_last);
            errors++;
          end
          if (out_text_last !== want.text_last) begin
            $display("%0t: out_text_last expected %b, got %b", $time, want.text_last,
                     out_text_last);
            errors++;
          end
        end
        chars_seen++;
        stall_left = draw_wait(chars_seen);
        // One long hold-off lets the output queue fill and back up the input.
        if (chars_seen == HOLD_AT) stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no progress for %0d cycles, %0d requests and %0d results outstanding",
             $time, IDLE_LIMIT, encoded_q.size(), decoded_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int base;
    // Extremes of the byte range, then one entity ending the text.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_str("&lt;", 1'b1);
    push_str("&#039;", 1'b0);
    // A second ampersand breaks the first match and starts a new one.
    push_str("&q&amp;", 1'b0);
    push_str("&#3x", 1'b0);
    // The text ends in the middle of an entity and again on a lone ampersand.
    push_str("&ap", 1'b1);
    push_str("&", 1'b1);
    base = encoded_q.size();
    while (encoded_q.size() < base + RAND_ITEMS) push_random_text();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (encoded_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; checked %0d decoded bytes, %0d of them entities.",
             bytes_sent, texts_seen, chars_seen, entities_decoded);
    $display("Included a %0d-cycle output hold-off that backed up the input.", HOLD_LEN);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
